// ----- hw/rtl/tmprof_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmprof_pkg
// Shared types, codes and widths of the trapezoid move profiler.
// ----------------------------------------------------------------------------
package tmprof_pkg;

   localparam int SPEED_W    = 11;
   localparam int CMD_W      = 12;
   localparam int PULSE_W    = 24;
   localparam int ENC_W      = 32;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // move kinds
   localparam logic [1:0] KIND_FWD   = 2'd0;
   localparam logic [1:0] KIND_LEFT  = 2'd1;
   localparam logic [1:0] KIND_RIGHT = 2'd2;

   // reported phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_ACCEL  = 2'd1;
   localparam logic [1:0] PH_CRUISE = 2'd2;
   localparam logic [1:0] PH_DECEL  = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_SPEED  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_STEP = 1'd1;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 11'd1024;
   localparam logic [SPEED_W-1:0] SPEED_STEP_RST = 11'd51;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ACCEL  = 4'b0010,
      ST_CRUISE = 4'b0100,
      ST_DECEL  = 4'b1000
   } move_state_type;

   typedef struct packed {
      logic               command;
      logic [1:0]         direction;
      logic [PULSE_W-1:0] target_pulses;
      logic [ENC_W-1:0]   encoder_count;
   } req_item_type;

   typedef struct packed {
      logic [CMD_W-1:0] left_speed;
      logic [CMD_W-1:0] right_speed;
      logic [1:0]       phase;
      logic             done_res;
   } rsp_item_type;

endpackage : tmprof_pkg
`default_nettype wire

// ----- hw/rtl/tmprof_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmprof_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tmprof_in_stage
   import tmprof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  out_free,
   output      logic                  fire,
   output      req_item_type          item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign fire       = valid_ff && out_free;
   assign req_tready = !valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in               = 1'b1;
         item_in.command        = req_tuser;
         item_in.direction      = req_tdata[1:0];
         item_in.target_pulses  = req_tdata[PULSE_W+1:2];
         item_in.encoder_count  = req_tdata[ENC_W+PULSE_W+1:PULSE_W+2];
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule : tmprof_in_stage
`default_nettype wire

// ----- hw/rtl/tmprof_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmprof_core
// Move state, config registers and the per-tick profile step.
// ----------------------------------------------------------------------------
module tmprof_core
   import tmprof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [SPEED_W-1:0]    csr_wdata,
   input  wire logic                  fire,
   input  wire req_item_type          item,
   output      rsp_item_type          result
);

   logic [SPEED_W-1:0] max_speed_ff, speed_step_ff;
   move_state_type     state_ff, state_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [1:0]         kind_ff, kind_in;
   logic [PULSE_W-1:0] total_ff, total_in;
   logic [PULSE_W-1:0] limit_ff, limit_in;
   logic [ENC_W-1:0]   base_ff, base_in;

   logic [SPEED_W-1:0] step;
   logic [ENC_W-1:0]   diff, enc_dist;
   logic [ENC_W:0]     dist_x2;
   logic               under_half;
   logic [SPEED_W:0]   ramp_sum;
   logic [SPEED_W-1:0] ramp_up, ramp_down;
   logic               decel_eval, zero_out;
   logic [CMD_W-1:0]   pos_speed, neg_speed;

   assign step       = (speed_step_ff == '0) ? SPEED_W'(1) : speed_step_ff;
   assign diff       = item.encoder_count - base_ff;
   assign enc_dist   = diff[ENC_W-1] ? (ENC_W'(0) - diff) : diff;
   assign dist_x2    = {enc_dist, 1'b0};
   assign under_half = dist_x2 < {{(ENC_W+1-PULSE_W){1'b0}}, total_ff};
   assign ramp_sum   = {1'b0, speed_ff} + {1'b0, step};
   // saturate at the top and at zero
   assign ramp_up    = (ramp_sum > {1'b0, max_speed_ff}) ? max_speed_ff
                                                         : ramp_sum[SPEED_W-1:0];
   assign ramp_down  = (speed_ff > step) ? (speed_ff - step) : '0;

   always_comb begin
      state_in   = state_ff;
      speed_in   = speed_ff;
      kind_in    = kind_ff;
      total_in   = total_ff;
      limit_in   = limit_ff;
      base_in    = base_ff;
      decel_eval = 1'b0;
      zero_out   = 1'b0;
      result.phase    = PH_IDLE;
      result.done_res = 1'b0;
      if (item.command == CMD_START) begin
         kind_in      = item.direction;
         total_in     = item.target_pulses;
         speed_in     = '0;
         limit_in     = '0;
         base_in      = item.encoder_count;
         state_in     = ST_ACCEL;
         result.phase = PH_ACCEL;
      end else begin
         case (state_ff)
            ST_ACCEL: begin
               if (under_half && (speed_ff < max_speed_ff)) begin
                  speed_in     = ramp_up;
                  result.phase = PH_ACCEL;
               end else if (under_half) begin
                  // cruise starts at distance zero, so it always emits this tick
                  limit_in     = total_ff - dist_x2[PULSE_W-1:0];
                  base_in      = item.encoder_count;
                  state_in     = ST_CRUISE;
                  result.phase = PH_CRUISE;
               end else begin
                  base_in    = item.encoder_count;
                  decel_eval = 1'b1;
               end
            end
            ST_CRUISE: begin
               if (enc_dist < {{(ENC_W-PULSE_W){1'b0}}, limit_ff}) begin
                  result.phase = PH_CRUISE;
               end else begin
                  base_in    = item.encoder_count;
                  decel_eval = 1'b1;
               end
            end
            ST_DECEL: begin
               decel_eval = 1'b1;
            end
            ST_IDLE: begin
               zero_out = 1'b1;
            end
            default: begin
               zero_out = 1'b1;
            end
         endcase
         if (decel_eval) begin
            speed_in     = ramp_down;
            result.phase = PH_DECEL;
            if (ramp_down == '0) begin
               result.done_res = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_DECEL;
            end
         end
      end

      pos_speed = {1'b0, speed_in};
      neg_speed = CMD_W'(0) - pos_speed;
      if (zero_out) begin
         result.left_speed  = '0;
         result.right_speed = '0;
      end else begin
         case (kind_in)
            KIND_FWD: begin
               result.left_speed  = pos_speed;
               result.right_speed = pos_speed;
            end
            KIND_LEFT: begin
               result.left_speed  = neg_speed;
               result.right_speed = pos_speed;
            end
            KIND_RIGHT: begin
               result.left_speed  = pos_speed;
               result.right_speed = neg_speed;
            end
            default: begin
               result.left_speed  = '0;
               result.right_speed = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= MAX_SPEED_RST;
         speed_step_ff <= SPEED_STEP_RST;
         state_ff      <= ST_IDLE;
         speed_ff      <= '0;
         kind_ff       <= '0;
         total_ff      <= '0;
         limit_ff      <= '0;
         base_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_MAX_SPEED:  max_speed_ff  <= csr_wdata;
               REG_SPEED_STEP: speed_step_ff <= csr_wdata;
               default:        ;
            endcase
         end
         if (fire) begin
            state_ff <= state_in;
            speed_ff <= speed_in;
            kind_ff  <= kind_in;
            total_ff <= total_in;
            limit_ff <= limit_in;
            base_ff  <= base_in;
         end
      end
   end

endmodule : tmprof_core
`default_nettype wire

// ----- hw/rtl/tmprof_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmprof_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module tmprof_out_stage
   import tmprof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire rsp_item_type          result,
   output      logic                  out_free,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic [1:0]            rsp_tuser,
   output      logic                  rsp_tlast
);

   logic         valid_ff, valid_in;
   rsp_item_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (fire) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.right_speed, res_ff.left_speed};
   assign rsp_tuser  = res_ff.phase;
   assign rsp_tlast  = res_ff.done_res;

endmodule : tmprof_out_stage
`default_nettype wire

// ----- hw/rtl/trapezoid_move_profiler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_move_profiler_top
// Trapezoidal speed profiler for a differential-drive move.
//
//   channel  direction  ports                          contents
//   req      in         req_tvalid/tready/tdata/tuser  start or tick item
//   rsp      out        rsp_tvalid/tready/tdata/tuser  wheel speeds, phase
//                       rsp_tlast                      move finished
//   csr      in         csr_we/addr/wdata              max_speed, speed_step
//
// one item per clock sustained while rsp is not stalled; a result is held
// in the result register for rsp; the move state updates in one pass through
// the core, between the input register and the result register
// reset (synchronous) empties both registers and returns the move to idle
// a stalled rsp holds its result while one more item waits in the input reg
// ----------------------------------------------------------------------------
module trapezoid_move_profiler_top
   import tmprof_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // direction[1:0], target_pulses[25:2], encoder_count[57:26], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // left_speed[11:0], right_speed[23:12]
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // phase
   output      logic [1:0]            rsp_tuser,
   output      logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [SPEED_W-1:0]    csr_wdata
);

   logic         out_free;
   logic         fire;
   req_item_type item;
   rsp_item_type result;

   tmprof_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .fire       (fire),
      .item       (item)
   );

   tmprof_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .result    (result)
   );

   tmprof_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : trapezoid_move_profiler_top
`default_nettype wire

// ----- hw/rtl/tmprof_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmprof_checker
// Port-level checks of the profiler, bound to the top level.
// ----------------------------------------------------------------------------
module tmprof_checker
   import tmprof_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser,
   input wire logic                  rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   // wheels are equal or mirrored
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] == rsp_tdata[23:12]
         || CMD_W'(rsp_tdata[11:0] + rsp_tdata[23:12]) == CMD_W'(0))
      else $error("wheel speeds neither equal nor mirrored");

   // a finished move reports decel at standstill
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == PH_DECEL && rsp_tdata == '0)
      else $error("done item not a decel stop");

   // idle ticks command no motion
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_IDLE |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("idle item with motion");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule : tmprof_checker

bind trapezoid_move_profiler_top tmprof_checker u_checker (.*);
`default_nettype wire
